@@ rtl/core/tar_pkg.sv @@
package tar_pkg;

  // Parameter defaults
  localparam int unsigned INNER_MAX_DEF  = 1024;
  localparam int unsigned AXIS_MAX_DEF   = 4096;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned AXIS_LEN_W    = 13;
  localparam int unsigned INNER_LEN_W   = 11;
  localparam int unsigned OUTER_LEN_W   = 17;
  localparam int unsigned CFG_W         = 17;
  localparam int unsigned RES_W         = 48;
  localparam int unsigned INDEX_W       = 12;
  localparam int unsigned OUTER_W       = 16;
  localparam int unsigned OUTER_CAP     = 65536;

  // Queue sizing
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH     = 4;

  // Reduction modes; any code at or above MODE_ARGMAX reports the index
  localparam logic [MODE_W-1:0] MODE_SUM    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARGMAX = 2'd2;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_AXIS_LEN  = 2'd1,
    REG_INNER_LEN = 2'd2,
    REG_OUTER_LEN = 2'd3
  } cfg_reg_e;

  // Classification of one element, handed from front to back
  typedef struct packed {
    logic first;
    logic axis_last;
    logic tensor_last;
  } item_ctl_t;

  function automatic int unsigned addr_bits(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Last counter position for a length register: 0 acts as 1, cap saturates
  function automatic logic [CFG_W-1:0] len_last(input logic [CFG_W-1:0] len,
                                                input logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] c;
    if (len == '0) begin
      c = CFG_W'(1);
    end else if (len > cap) begin
      c = cap;
    end else begin
      c = len;
    end
    return c - CFG_W'(1);
  endfunction

endpackage

@@ rtl/core/tar_ram.sv @@
module tar_ram #(
  parameter int unsigned W     = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [tar_pkg::addr_bits(DEPTH)-1:0]   waddr_i,
  input  logic [W-1:0]                           wdata_i,
  input  logic                                   re_i,
  input  logic [tar_pkg::addr_bits(DEPTH)-1:0]   raddr_i,
  output logic [W-1:0]                           rdata_o
);
  import tar_pkg::*;

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tar_fifo.sv @@
module tar_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [W-1:0]                 wdata_i,
  input  logic                         pop_i,
  output logic [W-1:0]                 rdata_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  import tar_pkg::*;

  localparam int unsigned PW = addr_bits(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign count_o = cnt_q;

endmodule

@@ rtl/core/tar_front.sv @@
module tar_front #(
  parameter int unsigned INNER_MAX  = tar_pkg::INNER_MAX_DEF,
  parameter int unsigned AXIS_MAX   = tar_pkg::AXIS_MAX_DEF,
  parameter int unsigned VALUE_BITS = tar_pkg::VALUE_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [VALUE_BITS-1:0]             value_i,
  input  logic [tar_pkg::addr_bits(AXIS_MAX)-1:0]  axis_lim_i,
  input  logic [tar_pkg::addr_bits(INNER_MAX)-1:0] inner_lim_i,
  input  logic [tar_pkg::OUTER_W-1:0]              outer_lim_i,
  input  logic                                     q_full_i,
  output logic                                     q_push_o,
  output tar_pkg::item_ctl_t                       q_ctl_o,
  output logic [tar_pkg::addr_bits(INNER_MAX)-1:0] q_slot_o,
  output logic [tar_pkg::INDEX_W-1:0]              q_pos_o,
  output logic [tar_pkg::RES_W-1:0]                q_value_o
);
  import tar_pkg::*;

  localparam int unsigned IW = addr_bits(INNER_MAX);
  localparam int unsigned AW = addr_bits(AXIS_MAX);

  logic [IW-1:0]      inner_pos_q, inner_pos_d;
  logic [AW-1:0]      axis_pos_q, axis_pos_d;
  logic [OUTER_W-1:0] outer_pos_q, outer_pos_d;
  logic               accept, inner_last, axis_last, outer_last;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // >= so that a limit lowered mid-tensor still wraps the counter
  assign inner_last = inner_pos_q >= inner_lim_i;
  assign axis_last  = axis_pos_q >= axis_lim_i;
  assign outer_last = outer_pos_q >= outer_lim_i;

  assign q_push_o              = accept;
  assign q_ctl_o.first         = (axis_pos_q == '0);
  assign q_ctl_o.axis_last     = axis_last;
  assign q_ctl_o.tensor_last   = inner_last && outer_last;
  assign q_slot_o              = inner_pos_q;
  assign q_pos_o               = INDEX_W'(axis_pos_q);
  assign q_value_o             = RES_W'(value_i);

  always_comb begin
    inner_pos_d = inner_pos_q;
    axis_pos_d  = axis_pos_q;
    outer_pos_d = outer_pos_q;
    if (accept) begin
      if (!inner_last) begin
        inner_pos_d = inner_pos_q + IW'(1);
      end else begin
        inner_pos_d = '0;
        if (!axis_last) begin
          axis_pos_d = axis_pos_q + AW'(1);
        end else begin
          axis_pos_d  = '0;
          outer_pos_d = outer_last ? '0 : outer_pos_q + OUTER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_pos_q <= '0;
      axis_pos_q  <= '0;
      outer_pos_q <= '0;
    end else begin
      inner_pos_q <= inner_pos_d;
      axis_pos_q  <= axis_pos_d;
      outer_pos_q <= outer_pos_d;
    end
  end

endmodule

@@ rtl/core/tar_back.sv @@
module tar_back #(
  parameter int unsigned INNER_MAX = tar_pkg::INNER_MAX_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [tar_pkg::MODE_W-1:0]               mode_i,
  input  logic                                     q_empty_i,
  output logic                                     q_pop_o,
  input  tar_pkg::item_ctl_t                       q_ctl_i,
  input  logic [tar_pkg::addr_bits(INNER_MAX)-1:0] q_slot_i,
  input  logic [tar_pkg::INDEX_W-1:0]              q_pos_i,
  input  logic [tar_pkg::RES_W-1:0]                q_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [tar_pkg::RES_W-1:0]         result_value_o,
  output logic [tar_pkg::INDEX_W-1:0]              result_index_o,
  output logic                                     last_o
);
  import tar_pkg::*;

  localparam int unsigned IW  = addr_bits(INNER_MAX);
  localparam int unsigned CW  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned OW  = RES_W + INDEX_W + 1;

  // Stage 1: store read issued
  logic               s1_v_q;
  item_ctl_t          s1_ctl_q;
  logic [IW-1:0]      s1_slot_q;
  logic [INDEX_W-1:0] s1_pos_q;
  logic [RES_W-1:0]   s1_value_q;

  // Stage 2: read data back, update and write
  logic               s2_v_q;
  item_ctl_t          s2_ctl_q;
  logic [IW-1:0]      s2_slot_q;
  logic [INDEX_W-1:0] s2_pos_q;
  logic [RES_W-1:0]   s2_value_q;

  // Last write, forwarded to the entry read at the same edge
  logic               wr_v_q;
  logic [IW-1:0]      wr_slot_q;
  logic [RES_W-1:0]   wr_part_q;
  logic [INDEX_W-1:0] wr_best_q;

  logic [RES_W-1:0]   rd_part, old_part, new_part;
  logic [INDEX_W-1:0] rd_best, old_best, new_best, res_idx;
  logic               fwd, greater;

  logic [CW-1:0]      out_cnt;
  logic [CW:0]        inflight;
  logic               out_empty, out_full, out_pop;
  logic [OW-1:0]      out_word;

  // Only pop when the result queue has room for everything in flight
  assign inflight = (CW+1)'(out_cnt) + (CW+1)'(s1_v_q) + (CW+1)'(s2_v_q);
  assign q_pop_o  = !q_empty_i && (inflight < (CW+1)'(OUT_DEPTH));

  tar_ram #(.W(RES_W), .DEPTH(INNER_MAX)) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_slot_q),
    .wdata_i (new_part),
    .re_i    (s1_v_q),
    .raddr_i (s1_slot_q),
    .rdata_o (rd_part)
  );

  tar_ram #(.W(INDEX_W), .DEPTH(INNER_MAX)) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_slot_q),
    .wdata_i (new_best),
    .re_i    (s1_v_q),
    .raddr_i (s1_slot_q),
    .rdata_o (rd_best)
  );

  always_comb begin
    fwd      = wr_v_q && (wr_slot_q == s2_slot_q);
    old_part = fwd ? wr_part_q : rd_part;
    old_best = fwd ? wr_best_q : rd_best;
    greater  = $signed(s2_value_q) > $signed(old_part);
    priority if (s2_ctl_q.first) begin
      new_part = s2_value_q;
      new_best = '0;
    end else if (mode_i == MODE_SUM) begin
      new_part = old_part + s2_value_q;
      new_best = old_best;
    end else if (greater) begin
      // ties keep the earlier position
      new_part = s2_value_q;
      new_best = s2_pos_q;
    end else begin
      new_part = old_part;
      new_best = old_best;
    end
    res_idx = (mode_i >= MODE_ARGMAX) ? new_best : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      s1_v_q <= q_pop_o;
      s2_v_q <= s1_v_q;
      wr_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_ctl_q   <= q_ctl_i;
      s1_slot_q  <= q_slot_i;
      s1_pos_q   <= q_pos_i;
      s1_value_q <= q_value_i;
    end
    s2_ctl_q   <= s1_ctl_q;
    s2_slot_q  <= s1_slot_q;
    s2_pos_q   <= s1_pos_q;
    s2_value_q <= s1_value_q;
    wr_slot_q  <= s2_slot_q;
    wr_part_q  <= new_part;
    wr_best_q  <= new_best;
  end

  assign out_pop = !out_empty && !out_stall_i;

  tar_fifo #(.W(OW), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q && s2_ctl_q.axis_last),
    .wdata_i ({new_part, res_idx, s2_ctl_q.tensor_last}),
    .pop_i   (out_pop),
    .rdata_o (out_word),
    .empty_o (out_empty),
    .full_o  (out_full),
    .count_o (out_cnt)
  );

  assign out_valid_o    = !out_empty;
  assign result_value_o = out_word[OW-1 -: RES_W];
  assign result_index_o = out_word[INDEX_W:1];
  assign last_o         = out_word[0] && !out_full | out_word[0];

endmodule

@@ rtl/core/tensor_axis_reduce.sv @@
// Reduces a row-major tensor stream along one axis: sum, maximum, or index of
// the first maximum, on signed fixed-point elements widened to 48 bits. One
// element is taken per clock cycle, sustained while the result output is not
// stalled; the limit is the single read-modify-write per cycle on the
// per-inner-position accumulator memory, whose one read and one write port are
// kept busy by a forwarding path. An element that closes an axis presents its
// result after passing the input queue, the store read and the update into the
// result queue. The front counts inner/axis/outer positions and tags each
// element; a four-entry queue separates it from the back, which owns the
// memories and a four-entry result queue, so either side may stall alone.
// There is no clearing pass after reset: on the first axis step every
// accumulator entry is overwritten without use of the value read from it.
// Program the registers only while no transaction is in flight.
module tensor_axis_reduce #(
  parameter int unsigned INNER_MAX  = tar_pkg::INNER_MAX_DEF,
  parameter int unsigned AXIS_MAX   = tar_pkg::AXIS_MAX_DEF,
  parameter int unsigned VALUE_BITS = tar_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  tar_pkg::cfg_reg_e                 cfg_index_i,
  input  logic [tar_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [VALUE_BITS-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tar_pkg::RES_W-1:0]  result_value_o,
  output logic [tar_pkg::INDEX_W-1:0]       result_index_o,
  output logic                              last_o
);
  import tar_pkg::*;

  localparam int unsigned IW = addr_bits(INNER_MAX);
  localparam int unsigned AW = addr_bits(AXIS_MAX);
  localparam int unsigned CTL_W = $bits(item_ctl_t);
  localparam int unsigned QW = CTL_W + IW + INDEX_W + RES_W;

  logic [MODE_W-1:0]  mode_q;
  logic [AW-1:0]      axis_lim_q;
  logic [IW-1:0]      inner_lim_q;
  logic [OUTER_W-1:0] outer_lim_q;

  // Length registers are kept as last counter positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SUM;
      axis_lim_q  <= '0;
      inner_lim_q <= '0;
      outer_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE: begin
          mode_q <= cfg_data_i[MODE_W-1:0];
        end
        REG_AXIS_LEN: begin
          axis_lim_q <= AW'(len_last(CFG_W'(cfg_data_i[AXIS_LEN_W-1:0]),
                                     CFG_W'(AXIS_MAX)));
        end
        REG_INNER_LEN: begin
          inner_lim_q <= IW'(len_last(CFG_W'(cfg_data_i[INNER_LEN_W-1:0]),
                                      CFG_W'(INNER_MAX)));
        end
        REG_OUTER_LEN: begin
          outer_lim_q <= OUTER_W'(len_last(CFG_W'(cfg_data_i[OUTER_LEN_W-1:0]),
                                           CFG_W'(OUTER_CAP)));
        end
        default: begin
        end
      endcase
    end
  end

  logic               f_push, q_full, q_empty, q_pop;
  item_ctl_t          f_ctl, b_ctl;
  logic [IW-1:0]      f_slot, b_slot;
  logic [INDEX_W-1:0] f_pos, b_pos;
  logic [RES_W-1:0]   f_value, b_value;
  logic [QW-1:0]      q_rdata;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  tar_front #(
    .INNER_MAX  (INNER_MAX),
    .AXIS_MAX   (AXIS_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .axis_lim_i  (axis_lim_q),
    .inner_lim_i (inner_lim_q),
    .outer_lim_i (outer_lim_q),
    .q_full_i    (q_full),
    .q_push_o    (f_push),
    .q_ctl_o     (f_ctl),
    .q_slot_o    (f_slot),
    .q_pos_o     (f_pos),
    .q_value_o   (f_value)
  );

  tar_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_item_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_ctl, f_slot, f_pos, f_value}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  assign {b_ctl, b_slot, b_pos, b_value} = q_rdata;

  tar_back #(.INNER_MAX(INNER_MAX)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .q_empty_i      (q_empty || (q_count == '0)),
    .q_pop_o        (q_pop),
    .q_ctl_i        (b_ctl),
    .q_slot_i       (b_slot),
    .q_pos_i        (b_pos),
    .q_value_i      (b_value),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .result_index_o (result_index_o),
    .last_o         (last_o)
  );

endmodule

@@ rtl/core/tar_checker.sv @@
module tar_checker #(
  parameter int unsigned AXIS_MAX = tar_pkg::AXIS_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  tar_pkg::cfg_reg_e          cfg_index_i,
  input  logic [tar_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [tar_pkg::RES_W-1:0]  result_value_o,
  input  logic [tar_pkg::INDEX_W-1:0] result_index_o,
  input  logic                       last_o
);
  import tar_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [CFG_W-1:0]  axis_lim_q, axis_new;
  logic [31:0]       pend_q, pend_d;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign axis_new = len_last(CFG_W'(cfg_data_i[AXIS_LEN_W-1:0]), CFG_W'(AXIS_MAX));

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 32'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 32'd1;
    end
  end

  // widest axis seen so far: an axis shortened mid-tensor can still close on a later position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SUM;
      axis_lim_q <= '0;
      pend_q     <= '0;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i && (cfg_index_i == REG_MODE)) begin
        mode_q <= cfg_data_i[MODE_W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == REG_AXIS_LEN) && (axis_new > axis_lim_q)) begin
        axis_lim_q <= axis_new;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(result_index_o) && $stable(last_o))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without an outstanding element");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q < MODE_ARGMAX) |-> result_index_o == '0)
    else $error("index reported outside argmax mode");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q >= MODE_ARGMAX) |-> CFG_W'(result_index_o) <= axis_lim_q)
    else $error("argmax index beyond axis length");

endmodule

bind tensor_axis_reduce tar_checker #(.AXIS_MAX(AXIS_MAX)) u_tar_checker (.*);
